@@ rtl/core/cst_pkg.sv @@
// ----------------------------------------------------------------------------
// cst_pkg: shared types and constants for the C subset tokenizer
// Token kinds, error causes, lexer modes and character class helpers.
// ----------------------------------------------------------------------------
`default_nettype none
package cst_pkg;

  localparam int unsigned MaxTokenLen = 1024;
  localparam int unsigned LineBits    = 16;

  localparam int unsigned KindW  = 6;
  localparam int unsigned CauseW = 4;
  localparam int unsigned LenW   = 10;
  localparam int unsigned LineW  = 16;

  typedef enum logic [15:0] {
    M_IDLE    = 16'h0001, M_EQ     = 16'h0002, M_LT     = 16'h0004,
    M_GT      = 16'h0008, M_BANG   = 16'h0010, M_AMP    = 16'h0020,
    M_BAR     = 16'h0040, M_SLASH  = 16'h0080, M_LCMT   = 16'h0100,
    M_BCMT    = 16'h0200, M_STR    = 16'h0400, M_CHOPEN = 16'h0800,
    M_CHESC   = 16'h1000, M_CHCLOSE = 16'h2000, M_IDENT = 16'h4000,
    M_NUM     = 16'h8000
  } mode_e;

  typedef enum logic [5:0] {
    K_ERR = 6'd0, K_EOF = 6'd1, K_IDENT = 6'd2, K_INTC = 6'd3, K_FLTC = 6'd4,
    K_CHRC = 6'd5, K_STR = 6'd6, K_LCMT = 6'd7, K_BCMT = 6'd8, K_KW0 = 6'd9,
    K_EQEQ = 6'd23, K_ASSIGN = 6'd24, K_LESS = 6'd25, K_LEQ = 6'd26,
    K_GREAT = 6'd27, K_GEQ = 6'd28, K_NEQ = 6'd29, K_HASH = 6'd30,
    K_LPAREN = 6'd31, K_RPAREN = 6'd32, K_SEMI = 6'd33, K_COMMA = 6'd34,
    K_PLUS = 6'd35, K_MINUS = 6'd36, K_STAR = 6'd37, K_SLASH = 6'd38,
    K_PERCENT = 6'd39, K_ANDAND = 6'd40, K_OROR = 6'd41, K_LSQ = 6'd42,
    K_RSQ = 6'd43, K_LCURLY = 6'd44, K_RCURLY = 6'd45
  } kind_e;

  typedef enum logic [3:0] {
    E_NONE = 4'd0, E_NONASCII = 4'd1, E_BANG = 4'd2, E_AMP = 4'd3,
    E_BAR = 4'd4, E_BCMT = 4'd5, E_STR = 4'd6, E_STRNL = 4'd7,
    E_CHCLOSE = 4'd8, E_ILLEGAL = 4'd9, E_DOT2 = 4'd10, E_HEXDOT = 4'd11,
    E_XPOS = 4'd12, E_HEXLET = 4'd13, E_LONEDOT = 4'd14
  } cause_e;

  typedef struct packed {
    logic [KindW-1:0]  kind;
    logic [CauseW-1:0] cause;
    logic [LenW-1:0]   len;
    logic [LineW-1:0]  line;
  } tok_t;

  localparam logic [1:0] FlFloat = 2'b01;
  localparam logic [1:0] FlHex   = 2'b10;

  function automatic logic is_alpha(input logic [7:0] b);
    return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z");
  endfunction

  function automatic logic is_digit(input logic [7:0] b);
    return b >= "0" && b <= "9";
  endfunction

  function automatic logic is_hexlet(input logic [7:0] b);
    return (b >= "a" && b <= "f") || (b >= "A" && b <= "F");
  endfunction

  // Match the 8-byte window against the keyword list.
  function automatic logic [KindW-1:0] ident_kind(input logic [63:0] w,
                                                   input logic [LenW-1:0] n);
    logic [KindW-1:0] k;
    k = K_IDENT;
    if (n == 10'd3 && w[23:0] == "int")      k = KindW'(K_KW0 + 0);
    if (n == 10'd5 && w[39:0] == "float")    k = KindW'(K_KW0 + 1);
    if (n == 10'd4 && w[31:0] == "char")     k = KindW'(K_KW0 + 2);
    if (n == 10'd2 && w[15:0] == "if")       k = KindW'(K_KW0 + 3);
    if (n == 10'd4 && w[31:0] == "else")     k = KindW'(K_KW0 + 4);
    if (n == 10'd3 && w[23:0] == "for")      k = KindW'(K_KW0 + 5);
    if (n == 10'd5 && w[39:0] == "while")    k = KindW'(K_KW0 + 6);
    if (n == 10'd6 && w[47:0] == "return")   k = KindW'(K_KW0 + 7);
    if (n == 10'd8 && w[63:0] == "continue") k = KindW'(K_KW0 + 8);
    if (n == 10'd6 && w[47:0] == "extern")   k = KindW'(K_KW0 + 9);
    if (n == 10'd6 && w[47:0] == "static")   k = KindW'(K_KW0 + 10);
    if (n == 10'd5 && w[39:0] == "break")    k = KindW'(K_KW0 + 11);
    if (n == 10'd7 && w[55:0] == "include")  k = KindW'(K_KW0 + 12);
    if (n == 10'd6 && w[47:0] == "define")   k = KindW'(K_KW0 + 13);
    return k;
  endfunction

endpackage
`default_nettype wire

@@ rtl/core/cst_if.sv @@
// ----------------------------------------------------------------------------
// cst_in_if / cst_out_if: valid-ready channels of the tokenizer
// Input carries one source byte; output carries one token.
// ----------------------------------------------------------------------------
`default_nettype none
interface cst_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] source_byte;
  logic       end_of_input;
  modport source (output valid, source_byte, end_of_input, input ready);
  modport sink   (input valid, source_byte, end_of_input, output ready);
endinterface

interface cst_out_if;
  logic        valid;
  logic        ready;
  logic [5:0]  token_kind;
  logic [3:0]  error_cause;
  logic [9:0]  token_length;
  logic [15:0] token_line;
  logic        last_result;
  modport source (output valid, token_kind, error_cause, token_length, token_line,
                  last_result, input ready);
  modport sink   (input valid, token_kind, error_cause, token_length, token_line,
                  last_result, output ready);
endinterface
`default_nettype wire

@@ rtl/core/cst_lexer.sv @@
// ----------------------------------------------------------------------------
// cst_lexer: one-byte lexer step
// Holds the lexer state; on each step consumes one byte and yields up to
// two tokens.
// ----------------------------------------------------------------------------
`default_nettype none
module cst_lexer #(
  parameter int unsigned MaxTokenLen = cst_pkg::MaxTokenLen,
  parameter int unsigned LineBits    = cst_pkg::LineBits
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           step_i,
  input  wire logic [7:0]     byte_i,
  input  wire logic           eoi_i,
  output cst_pkg::tok_t       tok0_o,
  output cst_pkg::tok_t       tok1_o,
  output logic [1:0]          ntok_o
);
  localparam int unsigned LenW = cst_pkg::LenW;
  localparam int unsigned LineW = cst_pkg::LineW;
  localparam logic [LenW-1:0] LenCap =
      (MaxTokenLen - 1 < 1023) ? LenW'(MaxTokenLen - 1) : LenW'(1023);
  localparam logic [LineW-1:0] LineCap =
      (LineBits < 16) ? LineW'((64'd1 << LineBits) - 1) : LineW'(65535);

  cst_pkg::mode_e     mode_q, mode_d;
  logic [LineW-1:0]   line_q, line_d, sline_q, sline_d;
  logic [LenW-1:0]    len_q, len_d;
  logic [63:0]        win_q, win_d;
  logic [7:0]         prev_q, prev_d;
  logic [1:0]         fl_q, fl_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= cst_pkg::M_IDLE;
      line_q  <= LineW'(1);
      sline_q <= LineW'(1);
      len_q   <= '0;
      win_q   <= '0;
      prev_q  <= '0;
      fl_q    <= '0;
    end else if (step_i) begin
      mode_q  <= mode_d;
      line_q  <= line_d;
      sline_q <= sline_d;
      len_q   <= len_d;
      win_q   <= win_d;
      prev_q  <= prev_d;
      fl_q    <= fl_d;
    end
  end

  function automatic cst_pkg::tok_t mk(input logic [5:0] k, input logic [3:0] c,
                                       input logic [LenW-1:0] n,
                                       input logic [LineW-1:0] l);
    cst_pkg::tok_t t;
    t.kind = k; t.cause = c; t.len = n; t.line = l;
    return t;
  endfunction

  always_comb begin
    cst_pkg::tok_t toks [2];
    logic [1:0]    n;
    logic          redo, grw, nl;
    logic [3:0]    cause;
    logic [5:0]    k;
    logic [LenW-1:0] glen;
    toks[0] = '0; toks[1] = '0;
    n = '0; redo = 1'b0; grw = 1'b0; nl = 1'b0; cause = '0; k = '0;
    mode_d = mode_q; line_d = line_q; sline_d = sline_q; len_d = len_q;
    win_d = win_q; prev_d = prev_q; fl_d = fl_q;
    glen = (len_q < LenCap) ? len_q + 1'b1 : len_q;

    if (eoi_i) begin
      unique case (mode_q)
        cst_pkg::M_IDLE: ;
        cst_pkg::M_BCMT: k = {2'b00, cst_pkg::E_BCMT};
        cst_pkg::M_STR: k = {2'b00, cst_pkg::E_STR};
        cst_pkg::M_CHOPEN, cst_pkg::M_CHESC: k = {2'b00, cst_pkg::E_NONASCII};
        cst_pkg::M_CHCLOSE: k = {2'b00, cst_pkg::E_CHCLOSE};
        default: k = 6'd0;
      endcase
      redo = 1'b1;  // reused below as "pending token to close"
    end else if (mode_q != cst_pkg::M_IDLE) begin
      unique case (mode_q)
        cst_pkg::M_EQ, cst_pkg::M_LT, cst_pkg::M_GT, cst_pkg::M_BANG: begin
          if (byte_i == "=") begin
            unique case (mode_q)
              cst_pkg::M_EQ: k = cst_pkg::K_EQEQ;
              cst_pkg::M_LT: k = cst_pkg::K_LEQ;
              cst_pkg::M_GT: k = cst_pkg::K_GEQ;
              default:       k = cst_pkg::K_NEQ;
            endcase
            toks[n[0]] = mk(k, cst_pkg::E_NONE, LenW'(2), sline_q); n = n + 1'b1;
            mode_d = cst_pkg::M_IDLE; fl_d = '0;
          end else redo = 1'b1;
        end
        cst_pkg::M_AMP, cst_pkg::M_BAR: begin
          if (byte_i == ((mode_q == cst_pkg::M_AMP) ? 8'h26 : 8'h7c)) begin
            k = (mode_q == cst_pkg::M_AMP) ? cst_pkg::K_ANDAND : cst_pkg::K_OROR;
            toks[n[0]] = mk(k, cst_pkg::E_NONE, LenW'(2), sline_q); n = n + 1'b1;
            mode_d = cst_pkg::M_IDLE; fl_d = '0;
          end else redo = 1'b1;
        end
        cst_pkg::M_SLASH: begin
          if (byte_i == "/") begin
            grw = 1'b1; mode_d = cst_pkg::M_LCMT;
          end else if (byte_i == "*") begin
            grw = 1'b1; mode_d = cst_pkg::M_BCMT;
          end else redo = 1'b1;
        end
        cst_pkg::M_LCMT: begin
          if (byte_i == 8'h0a) redo = 1'b1;
          else grw = 1'b1;
        end
        cst_pkg::M_BCMT: begin
          grw = 1'b1;
          nl = (byte_i == 8'h0a);
          if (byte_i == "/" && prev_q == "*" && glen >= LenW'(4)) begin
            toks[n[0]] = mk(cst_pkg::K_BCMT, cst_pkg::E_NONE, glen, sline_q);
            n = n + 1'b1;
            mode_d = cst_pkg::M_IDLE; fl_d = '0;
          end
        end
        cst_pkg::M_STR: begin
          if (byte_i == 8'h0a) begin
            toks[n[0]] = mk(cst_pkg::K_ERR, cst_pkg::E_STRNL, len_q, sline_q);
            n = n + 1'b1;
            mode_d = cst_pkg::M_IDLE; fl_d = '0;
            redo = 1'b1; k = 6'd63;  // closed already
          end else begin
            grw = 1'b1;
            if (byte_i == 8'h22) begin
              toks[n[0]] = mk(cst_pkg::K_STR, cst_pkg::E_NONE, glen, sline_q);
              n = n + 1'b1;
              mode_d = cst_pkg::M_IDLE; fl_d = '0;
            end
          end
        end
        cst_pkg::M_CHOPEN, cst_pkg::M_CHESC: begin
          grw = 1'b1;
          if (mode_q == cst_pkg::M_CHOPEN && byte_i == 8'h5c) begin
            mode_d = cst_pkg::M_CHESC;
          end else if (byte_i[7]) begin
            toks[n[0]] = mk(cst_pkg::K_ERR, cst_pkg::E_NONASCII, glen, sline_q);
            n = n + 1'b1;
            mode_d = cst_pkg::M_IDLE; fl_d = '0;
          end else begin
            nl = (byte_i == 8'h0a);
            mode_d = cst_pkg::M_CHCLOSE;
          end
        end
        cst_pkg::M_CHCLOSE: begin
          if (byte_i == 8'h27) begin
            grw = 1'b1;
            toks[n[0]] = mk(cst_pkg::K_CHRC, cst_pkg::E_NONE, glen, sline_q);
            n = n + 1'b1;
            mode_d = cst_pkg::M_IDLE; fl_d = '0;
          end else begin
            toks[n[0]] = mk(cst_pkg::K_ERR, cst_pkg::E_CHCLOSE, len_q, sline_q);
            n = n + 1'b1;
            mode_d = cst_pkg::M_IDLE; fl_d = '0;
            redo = 1'b1; k = 6'd63;
          end
        end
        cst_pkg::M_IDENT: begin
          if (cst_pkg::is_alpha(byte_i) || cst_pkg::is_digit(byte_i) || byte_i == "_") begin
            grw = 1'b1; win_d = {win_q[55:0], byte_i};
          end else redo = 1'b1;
        end
        cst_pkg::M_NUM: begin
          if (cst_pkg::is_digit(byte_i)) begin
          end else if (byte_i == ".") begin
            if (fl_q[0]) cause = cst_pkg::E_DOT2;
            else if (fl_q[1]) cause = cst_pkg::E_HEXDOT;
            else fl_d = fl_q | cst_pkg::FlFloat;
          end else if (byte_i == "x") begin
            if (len_q != LenW'(1) || prev_q != "0") cause = cst_pkg::E_XPOS;
            else fl_d = fl_q | cst_pkg::FlHex;
          end else if (cst_pkg::is_hexlet(byte_i)) begin
            if (!fl_q[1]) cause = cst_pkg::E_HEXLET;
          end else begin
            cause = 4'd15;  // ends the number normally
          end
          if (cause == 4'd15) redo = 1'b1;
          else if (cause != '0) begin
            toks[n[0]] = mk(cst_pkg::K_ERR, cause, len_q, sline_q); n = n + 1'b1;
            mode_d = cst_pkg::M_IDLE; fl_d = '0;
            redo = 1'b1; k = 6'd63;
          end else grw = 1'b1;
        end
        default: begin
          redo = 1'b1; k = 6'd63;
        end
      endcase
    end

    // Close a pending simple token (also on end of input).
    if (redo && k != 6'd63) begin
      if (eoi_i && mode_q != cst_pkg::M_IDLE && (mode_q == cst_pkg::M_BCMT ||
          mode_q == cst_pkg::M_STR || mode_q == cst_pkg::M_CHOPEN ||
          mode_q == cst_pkg::M_CHESC || mode_q == cst_pkg::M_CHCLOSE)) begin
        toks[n[0]] = mk(cst_pkg::K_ERR, k[3:0], len_q, sline_q); n = n + 1'b1;
      end else begin
        unique case (mode_q)
          cst_pkg::M_EQ: begin
            toks[n[0]] = mk(cst_pkg::K_ASSIGN, '0, LenW'(1), sline_q); n = n + 1'b1; end
          cst_pkg::M_LT: begin
            toks[n[0]] = mk(cst_pkg::K_LESS, '0, LenW'(1), sline_q); n = n + 1'b1; end
          cst_pkg::M_GT: begin
            toks[n[0]] = mk(cst_pkg::K_GREAT, '0, LenW'(1), sline_q); n = n + 1'b1; end
          cst_pkg::M_BANG: begin
            toks[n[0]] = mk(cst_pkg::K_ERR, cst_pkg::E_BANG, LenW'(1), sline_q);
            n = n + 1'b1; end
          cst_pkg::M_AMP: begin
            toks[n[0]] = mk(cst_pkg::K_ERR, cst_pkg::E_AMP, LenW'(1), sline_q);
            n = n + 1'b1; end
          cst_pkg::M_BAR: begin
            toks[n[0]] = mk(cst_pkg::K_ERR, cst_pkg::E_BAR, LenW'(1), sline_q);
            n = n + 1'b1; end
          cst_pkg::M_SLASH: begin
            toks[n[0]] = mk(cst_pkg::K_SLASH, '0, LenW'(1), sline_q); n = n + 1'b1; end
          cst_pkg::M_LCMT: begin
            toks[n[0]] = mk(cst_pkg::K_LCMT, '0, len_q, sline_q); n = n + 1'b1; end
          cst_pkg::M_IDENT: begin
            toks[n[0]] = mk(cst_pkg::ident_kind(win_q, len_q), '0, len_q, sline_q);
            n = n + 1'b1; end
          cst_pkg::M_NUM: begin
            if (len_q == LenW'(1) && prev_q == ".")
              toks[n[0]] = mk(cst_pkg::K_ERR, cst_pkg::E_LONEDOT, LenW'(1), sline_q);
            else
              toks[n[0]] = mk(fl_q[0] ? cst_pkg::K_FLTC : cst_pkg::K_INTC, '0, len_q,
                              sline_q);
            n = n + 1'b1;
          end
          default: ;
        endcase
      end
      mode_d = cst_pkg::M_IDLE; fl_d = '0;
    end

    if (grw) begin
      len_d = glen;
      prev_d = byte_i;
    end
    if (nl && line_q < LineCap) line_d = line_q + 1'b1;

    if (eoi_i) begin
      toks[n[0]] = mk(cst_pkg::K_EOF, '0, '0, line_q); n = n + 1'b1;
      len_d = '0; mode_d = cst_pkg::M_IDLE; fl_d = '0;
    end else if (mode_q == cst_pkg::M_IDLE || redo) begin
      // Examine the byte from the idle state.
      sline_d = line_q;
      len_d = '0;
      fl_d = '0;
      mode_d = cst_pkg::M_IDLE;
      k = '0;
      if (byte_i[7]) begin
        toks[n[0]] = mk(cst_pkg::K_ERR, cst_pkg::E_NONASCII, LenW'(1), line_q);
        n = n + 1'b1;
      end else if (byte_i == 8'h20 || (byte_i >= 8'h09 && byte_i <= 8'h0d)) begin
        if (byte_i == 8'h0a && line_q < LineCap) line_d = line_q + 1'b1;
      end else begin
        grw = 1'b1;
        unique case (byte_i)
          "=": mode_d = cst_pkg::M_EQ;
          "<": mode_d = cst_pkg::M_LT;
          ">": mode_d = cst_pkg::M_GT;
          "!": mode_d = cst_pkg::M_BANG;
          "&": mode_d = cst_pkg::M_AMP;
          "|": mode_d = cst_pkg::M_BAR;
          "/": mode_d = cst_pkg::M_SLASH;
          8'h22: mode_d = cst_pkg::M_STR;
          8'h27: mode_d = cst_pkg::M_CHOPEN;
          "#": k = cst_pkg::K_HASH;
          "(": k = cst_pkg::K_LPAREN;
          ")": k = cst_pkg::K_RPAREN;
          ";": k = cst_pkg::K_SEMI;
          ",": k = cst_pkg::K_COMMA;
          "+": k = cst_pkg::K_PLUS;
          "-": k = cst_pkg::K_MINUS;
          "*": k = cst_pkg::K_STAR;
          "%": k = cst_pkg::K_PERCENT;
          "[": k = cst_pkg::K_LSQ;
          "]": k = cst_pkg::K_RSQ;
          "{": k = cst_pkg::K_LCURLY;
          "}": k = cst_pkg::K_RCURLY;
          default: begin
            if (cst_pkg::is_alpha(byte_i) || byte_i == "_") begin
              mode_d = cst_pkg::M_IDENT; win_d = {56'd0, byte_i};
            end else if (cst_pkg::is_digit(byte_i) || byte_i == ".") begin
              mode_d = cst_pkg::M_NUM;
              fl_d = (byte_i == ".") ? cst_pkg::FlFloat : 2'b00;
            end else begin
              k = 6'd63;
            end
          end
        endcase
        if (k == 6'd63) begin
          grw = 1'b0;
          toks[n[0]] = mk(cst_pkg::K_ERR, cst_pkg::E_ILLEGAL, LenW'(1), line_q);
          n = n + 1'b1;
        end else if (k != '0) begin
          grw = 1'b0;
          toks[n[0]] = mk(k, '0, LenW'(1), line_q); n = n + 1'b1;
        end else begin
          len_d = (LenCap > 0) ? LenW'(1) : '0;
          prev_d = byte_i;
        end
      end
    end

    tok0_o = toks[0];
    tok1_o = toks[1];
    ntok_o = n;
  end

  // Mode stays idle after any end-of-input step.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_i && eoi_i) |=> mode_q == cst_pkg::M_IDLE)
    else $error("mode not idle after end of input");
  // End of input always yields at least the end-of-file token.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    eoi_i |-> ntok_o != 2'd0)
    else $error("no token on end of input");
  // Line counter never goes backwards.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(rst_ni) |-> line_q >= $past(line_q))
    else $error("line counter decreased");

endmodule
`default_nettype wire

@@ rtl/core/c_subset_tokenizer_top.sv @@
// ----------------------------------------------------------------------------
// c_subset_tokenizer_top: byte-serial C subset tokenizer
// Output: a token is shown in the cycle after the byte that completes it.
// Throughput: one byte per cycle while tokens are taken at once; a byte
// with two tokens holds the input while the second drains from the buffer.
// Reset: asynchronous, active low; lexer idle, line count 1, buffer empty.
// ----------------------------------------------------------------------------
`default_nettype none
module c_subset_tokenizer_top #(
  parameter int unsigned MaxTokenLen = cst_pkg::MaxTokenLen,
  parameter int unsigned LineBits    = cst_pkg::LineBits
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  cst_in_if.sink     in_i,
  cst_out_if.source  out_o
);
  cst_pkg::tok_t tok0, tok1;
  logic [1:0]    ntok;
  logic          step;

  // Two-entry output buffer: slot 0 is shown, slot 1 waits.
  cst_pkg::tok_t buf_q [2];
  logic [1:0]    last_q;
  logic [1:0]    cnt_q;
  logic          pop;

  assign pop = out_o.valid && out_o.ready;
  // Accept when every pending token will have left after this edge.
  assign in_i.ready = (cnt_q == 2'd0) || (cnt_q == 2'd1 && pop);
  assign step = in_i.valid && in_i.ready;

  cst_lexer #(.MaxTokenLen(MaxTokenLen), .LineBits(LineBits)) u_lexer (
    .clk_i, .rst_ni, .step_i(step), .byte_i(in_i.source_byte),
    .eoi_i(in_i.end_of_input), .tok0_o(tok0), .tok1_o(tok1), .ntok_o(ntok)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (step) begin
      cnt_q <= ntok;
    end else if (pop) begin
      cnt_q <= cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      buf_q[0]  <= tok0;
      buf_q[1]  <= tok1;
      last_q[0] <= (ntok == 2'd1);
      last_q[1] <= 1'b1;
    end else if (pop) begin
      buf_q[0]  <= buf_q[1];
      last_q[0] <= last_q[1];
    end
  end

  assign out_o.valid        = cnt_q != 2'd0;
  assign out_o.token_kind   = buf_q[0].kind;
  assign out_o.error_cause  = buf_q[0].cause;
  assign out_o.token_length = buf_q[0].len;
  assign out_o.token_line   = buf_q[0].line;
  assign out_o.last_result  = last_q[0];

  assert property (@(posedge clk_i) disable iff (!rst_ni) cnt_q != 2'd3)
    else $error("output buffer count out of range");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == 2'd2) |-> !in_i.ready)
    else $error("input taken while buffer full");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && cnt_q == 2'd2) |-> !out_o.last_result)
    else $error("first of two tokens marked last");

endmodule
`default_nettype wire
